[rtl/core/fh64_pkg.sv]
// fh64_pkg: shared constants, types and helpers for the fasthash64 stream hasher.
// No dependencies.
package fh64_pkg;

  localparam logic [63:0] HASH_SEED = 64'd3111696;
  localparam logic [63:0] HASH_MULT = 64'h880355f21e6d1965;
  localparam logic [63:0] MIX_MULT  = 64'h2127599bf4325c37;
  localparam int unsigned MIX_SHIFT_A = 23;
  localparam int unsigned MIX_SHIFT_B = 47;

  localparam logic [31:0] MAX_KEY_BYTES_DEF = 32'd65535;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam logic [3:0] WORD_BYTES = 4'd8;

  // one queued work entry: word already masked and pre-shifted
  typedef struct packed {
    logic [63:0] pre;
    logic        has_data;
    logic [15:0] total;
    logic        first;
    logic        last;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [63:0] xs(input logic [63:0] x, input int unsigned sh);
    xs = x ^ (x >> sh);
  endfunction

endpackage

[rtl/core/fh64_fifo.sv]
// fh64_fifo: small register queue between the front and back parts.
// Depends on fh64_pkg.
module fh64_fifo import fh64_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output qstat_t           stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/core/fh64_front.sv]
// fh64_front: accepts input beats, masks the word, clamps counts, builds queue entries.
// Depends on fh64_pkg.
module fh64_front import fh64_pkg::*; #(
  parameter logic [31:0] MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic        push,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic [15:0] total_bytes,
  input  logic        first_word,
  input  logic        last_word,
  input  qstat_t      q_stat,
  output logic        q_push,
  output qent_t       q_ent
);

  logic [3:0]  nbytes;
  logic [63:0] masked;

  assign nbytes = (valid_bytes > WORD_BYTES) ? WORD_BYTES : valid_bytes;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < nbytes) ? data_word[i*8 +: 8] : 8'h00;
    end
  end

  assign q_ent.pre      = xs(masked, MIX_SHIFT_A);
  assign q_ent.has_data = (nbytes != 4'd0);
  assign q_ent.total    = ({16'h0000, total_bytes} > MAX_KEY_BYTES) ?
                          MAX_KEY_BYTES[15:0] : total_bytes;
  assign q_ent.first    = first_word;
  assign q_ent.last     = last_word;
  assign q_push         = push && !q_stat.full;

endmodule

[rtl/core/fh64_mul.sv]
// fh64_mul: 64x64 multiply modulo 2^64 from three registered 32x32 partial products.
// No dependencies; product is valid in the cycle after the operands.
module fh64_mul (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] prod
);

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [63:0] ll_c;
  logic [31:0] lh_c;
  logic [31:0] hl_c;

  assign ll_c = a[31:0] * b[31:0];
  assign lh_c = a[31:0] * b[63:32];
  assign hl_c = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    p_ll <= ll_c;
    p_lh <= lh_c;
    p_hl <= hl_c;
  end

  assign prod = p_ll + {p_lh + p_hl, 32'h0000_0000};

endmodule

[rtl/core/fh64_back.sv]
// fh64_back: sequencer that seeds, mixes and finalizes the hash on one shared multiplier.
// Depends on fh64_pkg and fh64_mul.
module fh64_back import fh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  qent_t       q_ent,
  input  qstat_t      q_stat,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [63:0] hash_value
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED_M, S_SEED_R, S_MIX_M, S_MIX_R,
    S_HM_M, S_HM_R, S_FIN_M, S_FIN_R
  } state_t;

  state_t      state;
  qent_t       ent;
  logic [63:0] h;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] prod;
  logic [63:0] seeded;
  logic        res_valid;
  logic        fin_load;

  fh64_mul u_mul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  assign seeded     = HASH_SEED ^ prod;
  assign q_pop      = (state == S_IDLE) && !q_stat.empty;
  assign empty      = !res_valid;
  assign fin_load   = (state == S_FIN_R) && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            ent <= q_ent;
            if (q_ent.first) begin
              op_a  <= {48'h0, q_ent.total};
              op_b  <= HASH_MULT;
              state <= S_SEED_M;
            end else if (q_ent.has_data) begin
              op_a  <= q_ent.pre;
              op_b  <= MIX_MULT;
              state <= S_MIX_M;
            end else if (q_ent.last) begin
              op_a  <= xs(h, MIX_SHIFT_A);
              op_b  <= MIX_MULT;
              state <= S_FIN_M;
            end
          end
        end
        S_SEED_M: state <= S_SEED_R;
        S_SEED_R: begin
          h <= seeded;
          if (ent.has_data) begin
            op_a  <= ent.pre;
            op_b  <= MIX_MULT;
            state <= S_MIX_M;
          end else if (ent.last) begin
            op_a  <= xs(seeded, MIX_SHIFT_A);
            op_b  <= MIX_MULT;
            state <= S_FIN_M;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MIX_M: state <= S_MIX_R;
        S_MIX_R: begin
          op_a  <= h ^ xs(prod, MIX_SHIFT_B);
          op_b  <= HASH_MULT;
          state <= S_HM_M;
        end
        S_HM_M: state <= S_HM_R;
        S_HM_R: begin
          h <= prod;
          if (ent.last) begin
            op_a  <= xs(prod, MIX_SHIFT_A);
            op_b  <= MIX_MULT;
            state <= S_FIN_M;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN_M: state <= S_FIN_R;
        S_FIN_R: begin
          // operands held, so the product stays valid while the result slot is busy
          if (fin_load) begin
            hash_value <= xs(prod, MIX_SHIFT_B);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/fasthash64_stream_hasher.sv]
// fasthash64_stream_hasher: fasthash64 (seed 42^4) over a stream of 64-bit key words.
// The back part works through one queue entry before it pops the next: a data word needs a mix
// and a hash multiply, a word with no data is only popped, a first word adds seeding and a last
// word the final mix; the single shared 64-bit multiplier sets the pace, and the queue takes beats until full.
// A one-word key beat goes through the queue, the seed, mix, hash and final steps, then the result slot.
// Reset (rst, synchronous): queue and result slot empty, sequencer idle; hash state undefined.
module fasthash64_stream_hasher import fh64_pkg::*; #(
  parameter logic [31:0] MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic [15:0] total_bytes,
  input  logic        first_word,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] hash_value
);

  qstat_t q_stat;
  qent_t  wr_ent;
  qent_t  rd_ent;
  logic   q_push;
  logic   q_pop;

  assign full = q_stat.full;

  fh64_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .push        (push),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .total_bytes (total_bytes),
    .first_word  (first_word),
    .last_word   (last_word),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_ent       (wr_ent)
  );

  fh64_fifo #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_ent),
    .rd_en   (q_pop),
    .rd_data (rd_ent),
    .stat    (q_stat)
  );

  fh64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_ent      (rd_ent),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .hash_value (hash_value)
  );

  a_reset_empty: assert property (@(posedge clk) $fell(rst) |-> empty && !full)
    else $error("result or queue not empty after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_stat.empty)
    else $error("back part took an entry from an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_stat.full)
    else $error("front part wrote into a full queue");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule
